FILE: rtl/gfst_pkg.sv
// Shared types and constants for the ground-fault self-test sequencer.
package gfst_pkg;

  // Width of one window-length register.
  localparam int unsigned POLL_W = 10;

  // Default width of the poll tick counter.
  localparam int unsigned COUNT_BITS_DEF = 10;

  // Register indexes on the configuration port.
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_PULSE_POLLS   = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_RECOVER_POLLS = 1'b1;

  // Register reset values.
  localparam logic [POLL_W-1:0] PULSE_POLLS_RST   = 10'd50;
  localparam logic [POLL_W-1:0] RECOVER_POLLS_RST = 10'd20;

  // Result codes.
  localparam logic [1:0] RC_PASS       = 2'd0;
  localparam logic [1:0] RC_NO_ASSERT  = 2'd1;
  localparam logic [1:0] RC_NO_RELEASE = 2'd2;
  localparam logic [1:0] RC_TRIPPED    = 2'd3;

  // Sequencer phases.
  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PULSE   = 2'd1,
    PH_RECOVER = 2'd2,
    PH_DONE    = 2'd3
  } phase_t;

endpackage

FILE: rtl/gfst_window.sv
// Poll tick window counter step: advances the count and flags the window end.
module gfst_window #(
  parameter int unsigned COUNT_BITS = 10
) (
  input  logic [COUNT_BITS-1:0]     count,
  input  logic [gfst_pkg::POLL_W-1:0] polls,
  output logic [COUNT_BITS-1:0]     count_nxt,
  output logic                      win_end
);
  import gfst_pkg::*;

  // Wide enough for the register value and for the counter cap.
  localparam int unsigned WL_W = (COUNT_BITS + 1 > POLL_W + 1) ? COUNT_BITS + 1 : POLL_W + 1;

  logic [COUNT_BITS:0] inc;
  logic [WL_W-1:0]     inc_ext;
  logic [WL_W-1:0]     len;
  logic [WL_W-1:0]     cap;

  // The window lasts at least one tick and at most the counter's range.
  always_comb begin
    cap = WL_W'(1) << COUNT_BITS;
    len = WL_W'(polls);
    if (len == '0) begin
      len = WL_W'(1);
    end
    if (len > cap) begin
      len = cap;
    end
  end

  // Next count, cleared when the window closes.
  assign inc       = {1'b0, count} + (COUNT_BITS + 1)'(1);
  assign inc_ext   = WL_W'(inc);
  assign win_end   = (inc_ext >= len);
  assign count_nxt = win_end ? '0 : inc[COUNT_BITS-1:0];

endmodule

FILE: rtl/gfci_cal_self_test_sequencer.sv
// Top level of the ground-fault CAL self-test sequencer.
//
//   Channel | Direction | Handshake            | Payload
//   in_     | input     | in_valid / in_ready  | mode, fault_sense, cal_pin_level
//   out_    | output    | out_valid / out_ready| cal_drive, test_busy, test_done, result_code
//   cfg_    | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Each input beat is worked at once: the sequencer state and the result
// register load at the same edge, so one beat per cycle is sustained while out_ready is high.
// The result appears on the out_ side in the cycle after its input beat is taken.
// in_ready drops only while a result waits and out_ready is low.
// Synchronous active-low reset returns the sequencer to idle and the window
// registers to 50 and 20 ticks; cfg_ready is always high.
module gfci_cal_self_test_sequencer #(
  parameter int unsigned COUNT_BITS = gfst_pkg::COUNT_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // Input beats.
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic                          in_mode,
  input  logic                          in_fault_sense,
  input  logic                          in_cal_pin_level,
  // Result beats.
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic                          out_cal_drive,
  output logic                          out_test_busy,
  output logic                          out_test_done,
  output logic [1:0]                    out_result_code,
  // Configuration writes.
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [gfst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfst_pkg::POLL_W-1:0]   cfg_data
);
  import gfst_pkg::*;

  // Configuration registers.
  logic [POLL_W-1:0] pulse_polls_r;
  logic [POLL_W-1:0] recover_polls_r;

  // Sequencer state.
  phase_t                phase_r, phase_nxt;
  logic [COUNT_BITS-1:0] poll_count_r, poll_count_nxt;
  logic                  rest_level_r, rest_level_nxt;
  logic                  cal_level_r, cal_level_nxt;
  logic                  seen_pulse_r, seen_pulse_nxt;
  logic                  seen_after_r, seen_after_nxt;
  logic                  seen_release_r, seen_release_nxt;
  logic [1:0]            final_code_r, final_code_nxt;

  // Result register.
  logic       out_valid_r, out_valid_nxt;
  logic       cal_drive_r, cal_drive_nxt;
  logic       test_busy_r, test_busy_nxt;
  logic       test_done_r, test_done_nxt;
  logic [1:0] result_code_r, result_code_nxt;

  logic                  in_go;
  logic                  busy;
  logic [POLL_W-1:0]     win_polls;
  logic [COUNT_BITS-1:0] win_count_nxt;
  logic                  win_end;

  assign in_ready  = !out_valid_r || out_ready;
  assign in_go     = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign busy      = (phase_r == PH_PULSE) || (phase_r == PH_RECOVER);

  // The active window picks its length register.
  assign win_polls = (phase_r == PH_RECOVER) ? recover_polls_r : pulse_polls_r;

  gfst_window #(
    .COUNT_BITS (COUNT_BITS)
  ) u_window (
    .count     (poll_count_r),
    .polls     (win_polls),
    .count_nxt (win_count_nxt),
    .win_end   (win_end)
  );

  // Configuration register writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_polls_r   <= PULSE_POLLS_RST;
      recover_polls_r <= RECOVER_POLLS_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PULSE_POLLS:   pulse_polls_r   <= cfg_data;
        REG_RECOVER_POLLS: recover_polls_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Next state of the sequencer for the beat being taken.
  always_comb begin
    phase_nxt        = phase_r;
    poll_count_nxt   = poll_count_r;
    rest_level_nxt   = rest_level_r;
    cal_level_nxt    = cal_level_r;
    seen_pulse_nxt   = seen_pulse_r;
    seen_after_nxt   = seen_after_r;
    seen_release_nxt = seen_release_r;
    final_code_nxt   = final_code_r;
    if (in_go) begin
      if (in_mode) begin
        // A start while a window runs is ignored.
        if (!busy) begin
          if (in_fault_sense) begin
            final_code_nxt = RC_TRIPPED;
            phase_nxt      = PH_DONE;
          end else begin
            rest_level_nxt   = in_cal_pin_level;
            cal_level_nxt    = !in_cal_pin_level;
            poll_count_nxt   = '0;
            seen_pulse_nxt   = 1'b0;
            seen_after_nxt   = 1'b0;
            seen_release_nxt = 1'b0;
            final_code_nxt   = RC_PASS;
            phase_nxt        = PH_PULSE;
          end
        end
      end else begin
        case (phase_r)
          PH_PULSE: begin
            if (in_fault_sense) begin
              seen_pulse_nxt = 1'b1;
            end
            poll_count_nxt = win_count_nxt;
            if (win_end) begin
              cal_level_nxt = rest_level_r;
              phase_nxt     = PH_RECOVER;
            end
          end
          PH_RECOVER: begin
            if (in_fault_sense) begin
              seen_after_nxt = 1'b1;
            end else if (seen_pulse_r || seen_after_r) begin
              seen_release_nxt = 1'b1;
            end
            poll_count_nxt = win_count_nxt;
            if (win_end) begin
              if (!(seen_pulse_r || seen_after_nxt)) begin
                final_code_nxt = RC_NO_ASSERT;
              end else if (!seen_release_nxt) begin
                final_code_nxt = RC_NO_RELEASE;
              end else begin
                final_code_nxt = RC_PASS;
              end
              phase_nxt = PH_DONE;
            end
          end
          default: ;
        endcase
      end
    end
  end

  // Result beat built from the state after this beat.
  always_comb begin
    cal_drive_nxt   = cal_drive_r;
    test_busy_nxt   = test_busy_r;
    test_done_nxt   = test_done_r;
    result_code_nxt = result_code_r;
    out_valid_nxt   = out_valid_r && !out_ready;
    if (in_go) begin
      out_valid_nxt   = 1'b1;
      cal_drive_nxt   = cal_level_nxt;
      test_busy_nxt   = (phase_nxt == PH_PULSE) || (phase_nxt == PH_RECOVER);
      test_done_nxt   = (phase_nxt == PH_DONE);
      result_code_nxt = (phase_nxt == PH_DONE) ? final_code_nxt : RC_PASS;
    end
  end

  // Sequencer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r        <= PH_IDLE;
      poll_count_r   <= '0;
      rest_level_r   <= 1'b0;
      cal_level_r    <= 1'b0;
      seen_pulse_r   <= 1'b0;
      seen_after_r   <= 1'b0;
      seen_release_r <= 1'b0;
      final_code_r   <= RC_PASS;
      out_valid_r    <= 1'b0;
    end else begin
      phase_r        <= phase_nxt;
      poll_count_r   <= poll_count_nxt;
      rest_level_r   <= rest_level_nxt;
      cal_level_r    <= cal_level_nxt;
      seen_pulse_r   <= seen_pulse_nxt;
      seen_after_r   <= seen_after_nxt;
      seen_release_r <= seen_release_nxt;
      final_code_r   <= final_code_nxt;
      out_valid_r    <= out_valid_nxt;
    end
  end

  // Result payload register.
  always_ff @(posedge clk) begin
    cal_drive_r   <= cal_drive_nxt;
    test_busy_r   <= test_busy_nxt;
    test_done_r   <= test_done_nxt;
    result_code_r <= result_code_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cal_drive   = cal_drive_r;
  assign out_test_busy   = test_busy_r;
  assign out_test_done   = test_done_r;
  assign out_result_code = result_code_r;

  // A result never reports busy and done together.
  a_busy_done_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(test_busy_r && test_done_r))
    else $error("result reports busy and done together");

  // The result code is zero unless a test has finished.
  a_code_when_done: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !test_done_r) |-> (result_code_r == RC_PASS))
    else $error("result code set without test done");

  // A clean start enters the pulse window driving the opposite CAL level.
  a_start_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    (in_go && in_mode && !in_fault_sense && !busy) |=>
      (phase_r == PH_PULSE && cal_level_r == !rest_level_r && poll_count_r == '0))
    else $error("start did not open the pulse window");

  // Busy result matches the sequencer phase after the beat.
  a_busy_phase: assert property (@(posedge clk) disable iff (!rst_n)
    in_go |=> (test_busy_r == ((phase_r == PH_PULSE) || (phase_r == PH_RECOVER))))
    else $error("busy flag disagrees with phase");

endmodule

FILE: tb/gfci_status_checker.sv
// Checker for the GFCI self-test sequencer: predicts each status beat and compares it.
module gfci_status_checker #(
  parameter int unsigned COUNT_BITS = gfst_pkg::COUNT_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_ready,
  input  logic                           in_mode,
  input  logic                           in_fault_sense,
  input  logic                           in_cal_pin_level,
  input  logic                           out_valid,
  input  logic                           out_ready,
  input  logic                           out_cal_drive,
  input  logic                           out_test_busy,
  input  logic                           out_test_done,
  input  logic [1:0]                     out_result_code,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [gfst_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [gfst_pkg::POLL_W-1:0]    cfg_data,
  output int                             fail_count,
  output int                             pending,
  output int                             status_checked,
  output int                             tests_passed,
  output int                             tests_no_assert,
  output int                             tests_no_release,
  output int                             tests_tripped
);
  timeunit 1ns;
  timeprecision 1ps;
  import gfst_pkg::*;

  typedef struct packed {
    logic       cal_drive;
    logic       test_busy;
    logic       test_done;
    logic [1:0] result_code;
  } status_t;

  // Window registers as last written over the configuration port.
  logic [POLL_W-1:0] pulse_polls_q;
  logic [POLL_W-1:0] recover_polls_q;

  // Sequencer state kept alongside the block.
  phase_t                seq_phase;
  logic [COUNT_BITS-1:0] tick_count;
  logic                  rest_level;
  logic                  cal_level;
  logic                  seen_in_pulse;
  logic                  seen_late;
  logic                  seen_release;
  logic [1:0]            final_code;

  // Status beats predicted but not yet seen on the output.
  status_t expected_status[$];

  // Counts one tick of the open window; true when this tick closes it.
  // A register value of zero still gives a one-tick window.
  function automatic bit window_ends(input logic [POLL_W-1:0] len_reg);
    int span;
    int next_count;
    span = (len_reg == '0) ? 1 : int'(len_reg);
    if (span > (1 << COUNT_BITS)) span = 1 << COUNT_BITS;
    next_count = int'(tick_count) + 1;
    if (next_count >= span) begin
      tick_count = '0;
      return 1'b1;
    end
    tick_count = next_count[COUNT_BITS-1:0];
    return 1'b0;
  endfunction

  // Applies one input beat to the sequencer state and returns the status it reports.
  task automatic predict_status(input logic mode, input logic fault, input logic pin,
                                output status_t status);
    if (mode) begin
      // A start is ignored while a window runs.
      if (seq_phase != PH_PULSE && seq_phase != PH_RECOVER) begin
        if (fault) begin
          final_code = RC_TRIPPED;
          seq_phase  = PH_DONE;
          tests_tripped++;
        end else begin
          rest_level    = pin;
          cal_level     = ~pin;
          tick_count    = '0;
          seen_in_pulse = 1'b0;
          seen_late     = 1'b0;
          seen_release  = 1'b0;
          final_code    = RC_PASS;
          seq_phase     = PH_PULSE;
        end
      end
    end else if (seq_phase == PH_PULSE) begin
      if (fault) seen_in_pulse = 1'b1;
      if (window_ends(pulse_polls_q)) begin
        cal_level = rest_level;
        seq_phase = PH_RECOVER;
      end
    end else if (seq_phase == PH_RECOVER) begin
      // A release only counts once some assertion has been seen.
      if (fault) seen_late = 1'b1;
      else if (seen_in_pulse || seen_late) seen_release = 1'b1;
      if (window_ends(recover_polls_q)) begin
        if (!(seen_in_pulse || seen_late)) begin
          final_code = RC_NO_ASSERT;
          tests_no_assert++;
        end else if (!seen_release) begin
          final_code = RC_NO_RELEASE;
          tests_no_release++;
        end else begin
          final_code = RC_PASS;
          tests_passed++;
        end
        seq_phase = PH_DONE;
      end
    end
    status.cal_drive   = cal_level;
    status.test_busy   = (seq_phase == PH_PULSE) || (seq_phase == PH_RECOVER);
    status.test_done   = (seq_phase == PH_DONE);
    // The code field reads zero until a test has finished.
    status.result_code = (seq_phase == PH_DONE) ? final_code : '0;
  endtask

  function automatic void check_field(input string field, input logic [1:0] want,
                                      input logic [1:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, got %0d", field, want, got);
      fail_count++;
    end
  endfunction

  // Track configuration, check status beats against the oldest prediction, then predict.
  always @(posedge clk) begin
    status_t predicted;
    if (!rst_n) begin
      pulse_polls_q   = PULSE_POLLS_RST;
      recover_polls_q = RECOVER_POLLS_RST;
      seq_phase       = PH_IDLE;
      tick_count      = '0;
      rest_level      = 1'b0;
      cal_level       = 1'b0;
      seen_in_pulse   = 1'b0;
      seen_late       = 1'b0;
      seen_release    = 1'b0;
      final_code      = RC_PASS;
      expected_status.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_PULSE_POLLS) pulse_polls_q = cfg_data;
        else if (cfg_index == REG_RECOVER_POLLS) recover_polls_q = cfg_data;
      end
      if (out_valid && out_ready) begin
        status_checked++;
        if (expected_status.size() == 0) begin
          $error("status beat arrived with no input beat waiting for it");
          fail_count++;
        end else begin
          predicted = expected_status.pop_front();
          check_field("cal_drive", 2'(predicted.cal_drive), 2'(out_cal_drive));
          check_field("test_busy", 2'(predicted.test_busy), 2'(out_test_busy));
          check_field("test_done", 2'(predicted.test_done), 2'(out_test_done));
          check_field("result_code", predicted.result_code, out_result_code);
        end
      end
      if (in_valid && in_ready) begin
        predict_status(in_mode, in_fault_sense, in_cal_pin_level, predicted);
        expected_status.push_back(predicted);
      end
    end
    pending = expected_status.size();
  end

endmodule

FILE: tb/tb_gfci_cal_self_test_sequencer.sv
// Testbench top for the GFCI self-test sequencer: clock, reset, beat traffic and verdict.
module tb_gfci_cal_self_test_sequencer;
  timeunit 1ns;
  timeprecision 1ps;
  import gfst_pkg::*;

  localparam int CLK_PERIOD   = 8;
  localparam int RESET_CYCLES = 11;
  localparam int RANDOM_ITEMS = 320;
  localparam int LONG_HOLD    = 60;
  localparam int STALL_LIMIT  = 2000;

  // Fault patterns driven across the two windows of one self-test.
  typedef enum int {
    KIND_PASS,
    KIND_SILENT,
    KIND_STUCK,
    KIND_LATE,
    KIND_NOISE
  } test_kind_t;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic                 in_mode;
  logic                 in_fault_sense;
  logic                 in_cal_pin_level;
  logic                 out_valid;
  logic                 out_ready;
  logic                 out_cal_drive;
  logic                 out_test_busy;
  logic                 out_test_done;
  logic [1:0]           out_result_code;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [POLL_W-1:0]    cfg_data;

  int fail_count;
  int pending;
  int status_checked;
  int tests_passed;
  int tests_no_assert;
  int tests_no_release;
  int tests_tripped;

  // Effective window lengths as last written.
  int pulse_len   = PULSE_POLLS_RST;
  int recover_len = RECOVER_POLLS_RST;

  int beats_sent;
  int window_items;
  int reg_writes;
  int hold_requests;
  int holds_done;
  int idle_cycles;
  bit quiet_tx;
  bit quiet_rx;

  always #(CLK_PERIOD / 2) clk = ~clk;

  gfci_cal_self_test_sequencer dut (.*);

  gfci_status_checker u_checker (.*);

  // Watchdog: ends the run when no beat moves on any channel for too long.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("No beat moved for %0d cycles.", idle_cycles);
      $display("tb_gfci_cal_self_test_sequencer: FAIL");
      $finish;
    end
  end

  // Result side: a random stall before each beat, with one long hold-off on request.
  initial begin
    int stall;
    out_ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      if ($urandom_range(0, 39) == 0) quiet_rx = !quiet_rx;
      if (holds_done < hold_requests) begin
        holds_done++;
        stall = LONG_HOLD;
      end else begin
        stall = quiet_rx ? 0 : $urandom_range(0, 5);
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  // Offers one input beat after a random gap; called and returns at a falling edge.
  task automatic send_beat(input logic mode, input logic fault, input logic pin);
    int gap;
    if ($urandom_range(0, 39) == 0) quiet_tx = !quiet_tx;
    gap = quiet_tx ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_mode          <= mode;
    in_fault_sense   <= fault;
    in_cal_pin_level <= pin;
    in_valid         <= 1'b1;
    do @(posedge clk); while (!in_ready);
    @(negedge clk);
    beats_sent++;
  endtask

  // Writes one window register and notes the length the block will use.
  task automatic write_window(input logic [CFG_IDX_W-1:0] idx, input logic [POLL_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
    if (idx == REG_PULSE_POLLS) pulse_len = (value == '0) ? 1 : int'(value);
    else recover_len = (value == '0) ? 1 : int'(value);
    reg_writes++;
  endtask

  // Lets every predicted status beat drain, then lets the output register settle.
  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  function automatic logic fault_for(input test_kind_t kind, input bit in_pulse, input int pos,
                                     input int span);
    case (kind)
      KIND_PASS:   return in_pulse ? ((pos == span - 1) ? 1'b1 : 1'($urandom)) : 1'b0;
      KIND_SILENT: return 1'b0;
      KIND_STUCK:  return in_pulse ? logic'(pos >= span / 2) : 1'b1;
      KIND_LATE: begin
        if (in_pulse) return 1'b0;
        if (pos == 0) return 1'b1;
        return (pos == span - 1) ? 1'b0 : 1'($urandom);
      end
      default:     return 1'($urandom);
    endcase
  endfunction

  // One full self-test: start, pulse ticks, recover ticks. With noise, ignored starts fall
  // inside the windows, and ticks or a tripped start may follow the finished test.
  task automatic run_self_test(input test_kind_t kind, input logic pin, input bit noisy);
    bit in_pulse;
    int pos;
    send_beat(1'b1, 1'b0, pin);
    window_items++;
    for (int t = 0; t < pulse_len + recover_len; t++) begin
      in_pulse = (t < pulse_len);
      pos = in_pulse ? t : t - pulse_len;
      if (noisy && $urandom_range(0, 19) == 0) send_beat(1'b1, 1'($urandom), 1'($urandom));
      send_beat(1'b0, fault_for(kind, in_pulse, pos, in_pulse ? pulse_len : recover_len),
                1'($urandom));
      window_items++;
    end
    if (noisy) begin
      repeat ($urandom_range(0, 2)) send_beat(1'b0, 1'($urandom), 1'($urandom));
      if ($urandom_range(0, 4) == 0) send_beat(1'b1, 1'b1, 1'($urandom));
    end
  endtask

  // Stimulus and verdict.
  initial begin
    logic [POLL_W-1:0] pulse_val;
    logic [POLL_W-1:0] recover_val;
    int phase_no;
    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_mode          = 1'b0;
    in_fault_sense   = 1'b0;
    in_cal_pin_level = 1'b0;
    cfg_valid        = 1'b0;
    cfg_index        = REG_PULSE_POLLS;
    cfg_data         = '0;
    repeat (RESET_CYCLES) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Ticks while idle, a start with the fault already asserted, then a tick while done.
    send_beat(1'b0, 1'b1, 1'b1);
    send_beat(1'b0, 1'b0, 1'b0);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b0, 1'b1, 1'b1);

    // Zero-length windows run as one tick each; cover pass, no-assert and no-release.
    wait_quiet();
    write_window(REG_PULSE_POLLS, '0);
    write_window(REG_RECOVER_POLLS, '0);
    run_self_test(KIND_PASS, 1'b0, 1'b0);
    run_self_test(KIND_SILENT, 1'b1, 1'b0);
    run_self_test(KIND_STUCK, 1'b0, 1'b0);

    // Starts offered while busy are ignored; a start once done begins a new test.
    wait_quiet();
    write_window(REG_PULSE_POLLS, POLL_W'(3));
    write_window(REG_RECOVER_POLLS, POLL_W'(2));
    send_beat(1'b1, 1'b0, 1'b1);
    send_beat(1'b1, 1'b1, 1'b0);
    send_beat(1'b0, 1'b1, 1'b0);
    send_beat(1'b1, 1'b0, 1'b0);
    send_beat(1'b0, 1'b0, 1'b1);
    send_beat(1'b0, 1'b0, 1'b0);
    send_beat(1'b0, 1'b0, 1'b0);
    send_beat(1'b0, 1'b0, 1'b0);
    run_self_test(KIND_LATE, 1'b1, 1'b0);

    // Random phases: mostly short windows, once the reset lengths, long output holds twice.
    window_items = 0;
    phase_no     = 0;
    while (window_items < RANDOM_ITEMS) begin
      if (phase_no == 1) begin
        pulse_val   = PULSE_POLLS_RST;
        recover_val = RECOVER_POLLS_RST;
      end else begin
        pulse_val   = ($urandom_range(0, 7) == 0) ? POLL_W'($urandom_range(0, 1))
                                                  : POLL_W'($urandom_range(2, 12));
        recover_val = ($urandom_range(0, 7) == 0) ? POLL_W'($urandom_range(0, 1))
                                                  : POLL_W'($urandom_range(2, 12));
      end
      wait_quiet();
      write_window(REG_PULSE_POLLS, pulse_val);
      write_window(REG_RECOVER_POLLS, recover_val);
      if (phase_no == 0 || phase_no == 2) hold_requests++;
      repeat ((phase_no == 1) ? 2 : $urandom_range(3, 6)) begin
        run_self_test(test_kind_t'($urandom_range(0, 4)), 1'($urandom), 1'b1);
      end
      phase_no++;
    end

    // Long windows: the tick counter climbs into its upper bits once.
    wait_quiet();
    write_window(REG_PULSE_POLLS, POLL_W'(300));
    write_window(REG_RECOVER_POLLS, POLL_W'(40));
    run_self_test(test_kind_t'($urandom_range(0, 4)), 1'($urandom), 1'b1);

    wait_quiet();
    $display("Sent %0d input beats and checked %0d status beats after %0d register writes.",
             beats_sent, status_checked, reg_writes);
    $display("Tests ended: %0d pass, %0d no_assert, %0d no_release, %0d already_tripped.",
             tests_passed, tests_no_assert, tests_no_release, tests_tripped);
    if (fail_count == 0) begin
      $display("tb_gfci_cal_self_test_sequencer: PASS");
    end else begin
      $display("tb_gfci_cal_self_test_sequencer: FAIL");
    end
    $finish;
  end

endmodule
